// ===== hw/rtl/dtd_pkg.sv =====
// Shared types and constants for the disparity-to-depth pipeline.
// No dependencies; every other file in this block depends on it.
package dtd_pkg;

    localparam int DISP_W     = 16;   // disparity, signed Q11.4
    localparam int FACTOR_W   = 24;   // focal length and baseline, Q16.8
    localparam int CENTER_W   = 16;   // principal points, Q12.4
    localparam int DEPTH_W    = 32;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;

    localparam int PROD_W     = 2 * FACTOR_W;          // focal * baseline
    localparam int INT_SHIFT  = 12;                    // Q.8 * Q.8 / Q.4 -> integer
    localparam int FRAC_SHIFT = 4;                     // Q.8 * Q.8 / Q.4 -> Q.16
    localparam int NUM_W      = PROD_W + FRAC_SHIFT;
    localparam int DEN_W      = 17;                    // positive d + offset, max 98301
    localparam int SUM_W      = DEN_W + 1;             // signed d + offset
    localparam int QUO_W      = 32;
    localparam int HI_W       = NUM_W - QUO_W;
    localparam int INT_DEPTH_W = 16;

    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL     = 3'd0,
        REG_BASELINE  = 3'd1,
        REG_LEFT_COL  = 3'd2,
        REG_RIGHT_COL = 3'd3,
        REG_FORMAT    = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        FMT_INT = 1'b0,
        FMT_Q16 = 1'b1
    } fmt_t;

    // Divider payload: qn holds the unconsumed numerator bits at the top and
    // the quotient bits produced so far at the bottom.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] qn;
        logic             inv;
        logic             over;
        logic             frac_nz;
    } dtd_div_t;

endpackage

// ===== hw/rtl/dtd_disp_if.sv =====
// Input channel: one disparity pixel per item.
// Depends on dtd_pkg.
interface dtd_disp_if;
    logic                             valid;
    logic                             ready;
    logic signed [dtd_pkg::DISP_W-1:0] disparity;

    modport source (output valid, output disparity, input ready);
    modport sink   (input valid, input disparity, output ready);
endinterface

// ===== hw/rtl/dtd_depth_if.sv =====
// Output channel: one depth result per item.
// Depends on dtd_pkg.
interface dtd_depth_if;
    logic                        valid;
    logic                        ready;
    logic [dtd_pkg::DEPTH_W-1:0] depth_value;
    logic                        invalid;

    modport source (output valid, output depth_value, output invalid, input ready);
    modport sink   (input valid, input depth_value, input invalid, output ready);
endinterface

// ===== hw/rtl/dtd_div_stage.sv =====
// One stage of the pipelined restoring divider: BITS_PER_STAGE quotient bits.
// Depends on dtd_pkg.
module dtd_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  dtd_pkg::dtd_div_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output dtd_pkg::dtd_div_t dn_data
);
    import dtd_pkg::*;

    logic     valid_reg;
    dtd_div_t data_reg;
    dtd_div_t data_next;
    logic [DEN_W:0] trial;
    logic           bit_set;

    // Shift in the next numerator bit, subtract when it fits.
    always_comb
    begin
        data_next = up_data;
        trial     = '0;
        bit_set   = 1'b0;
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            trial   = {data_next.rem, data_next.qn[QUO_W-1]};
            bit_set = (trial >= {1'b0, data_next.den});
            data_next.qn = {data_next.qn[QUO_W-2:0], bit_set};
            if (bit_set)
            begin
                data_next.rem = DEN_W'(trial - {1'b0, data_next.den});
            end
            else
            begin
                data_next.rem = trial[DEN_W-1:0];
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

// ===== hw/rtl/disparity_to_depth_top.sv =====
// Disparity-to-depth triangulation pipeline, top level.
// Depends on dtd_pkg, dtd_disp_if, dtd_depth_if and dtd_div_stage.
//
//  channel  | role   | payload
//  ---------+--------+-------------------------------------------------
//  pixel    | sink   | disparity (signed Q11.4)
//  result   | source | depth_value (int or Q16.16), invalid
//  wr_*     | write  | wr_en, wr_index (register number), wr_data
//
// One item per clock sustained while result.ready holds. There are nineteen
// register stages: a multiply stage, a numerator set-up stage, sixteen
// radix-4 restoring divider stages and the output register; the accepting
// edge loads the first.
// Every stage holds its own valid bit and its ready is "empty or the next
// stage moves", so bubbles close up under a stall and pixels keep entering
// while a result waits, until every stage is full. Reset clears valid bits
// and all configuration registers; no clearing pass is needed.
module disparity_to_depth_top (
    input  logic                             clk,
    input  logic                             rst_n,
    dtd_disp_if.sink                         pixel,
    dtd_depth_if.source                      result,
    input  logic                             wr_en,
    input  logic [dtd_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [dtd_pkg::CFG_DATA_W-1:0]   wr_data
);
    import dtd_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FACTOR_W-1:0] focal_reg;
    logic [FACTOR_W-1:0] baseline_reg;
    logic [CENTER_W-1:0] left_col_reg;
    logic [CENTER_W-1:0] right_col_reg;
    fmt_t                format_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_reg     <= '0;
            baseline_reg  <= '0;
            left_col_reg  <= '0;
            right_col_reg <= '0;
            format_reg    <= FMT_INT;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FOCAL:     focal_reg     <= wr_data[FACTOR_W-1:0];
                REG_BASELINE:  baseline_reg  <= wr_data[FACTOR_W-1:0];
                REG_LEFT_COL:  left_col_reg  <= wr_data[CENTER_W-1:0];
                REG_RIGHT_COL: right_col_reg <= wr_data[CENTER_W-1:0];
                REG_FORMAT:    format_reg    <= fmt_t'(wr_data[0]);
                default:       ; // unknown index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: guards, denominator and focal * baseline product
    // ------------------------------------------------------------------
    logic                     s1_valid_reg;
    logic                     s1_ready;
    logic [PROD_W-1:0]        s1_prod_reg;
    logic [DEN_W-1:0]         s1_den_reg;
    logic                     s1_inv_reg;
    logic signed [SUM_W-1:0]  offset;
    logic signed [SUM_W-1:0]  den_sum;
    logic                     den_ok;
    logic                     in_guard;
    logic                     s2_ready;

    // Offset applies only when both principal points are set.
    assign offset = (left_col_reg != '0 && right_col_reg != '0)
                  ? $signed({2'b00, right_col_reg}) - $signed({2'b00, left_col_reg})
                  : '0;
    assign den_sum  = SUM_W'(pixel.disparity) + offset;
    assign den_ok   = !den_sum[SUM_W-1] && (den_sum != '0);
    assign in_guard = pixel.disparity[DISP_W-1] || (pixel.disparity == '0)
                   || (focal_reg == '0) || (baseline_reg == '0);

    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign pixel.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= pixel.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pixel.valid)
        begin
            s1_prod_reg <= PROD_W'(focal_reg) * PROD_W'(baseline_reg);
            s1_den_reg  <= den_sum[DEN_W-1:0];
            s1_inv_reg  <= in_guard || !den_ok;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale the numerator for the format, detect 32-bit overflow
    // and seed the divider with the top numerator bits.
    // ------------------------------------------------------------------
    logic                s2_valid_reg;
    dtd_div_t            s2_data_reg;
    dtd_div_t            s2_data_next;
    logic [NUM_W-1:0]    num_scaled;
    logic [HI_W-1:0]     num_hi;
    logic                num_over;

    logic                div_valid [0:DIV_STAGES];
    logic                div_ready [0:DIV_STAGES];
    dtd_div_t            div_data  [0:DIV_STAGES];

    assign num_scaled = (format_reg == FMT_Q16)
                      ? {s1_prod_reg, {FRAC_SHIFT{1'b0}}}
                      : NUM_W'(s1_prod_reg >> INT_SHIFT);
    assign num_hi     = num_scaled[NUM_W-1:QUO_W];
    // Quotient needs more than 32 bits exactly when the top part reaches den.
    assign num_over   = (num_hi >= HI_W'(s1_den_reg));

    always_comb
    begin
        s2_data_next.rem     = num_over ? '0 : num_hi[DEN_W-1:0];
        s2_data_next.den     = s1_den_reg;
        s2_data_next.qn      = num_scaled[QUO_W-1:0];
        s2_data_next.inv     = s1_inv_reg;
        s2_data_next.over    = num_over;
        s2_data_next.frac_nz = (s1_prod_reg[INT_SHIFT-1:0] != '0);
    end

    assign s2_ready = !s2_valid_reg || div_ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_data_reg <= s2_data_next;
        end
    end

    assign div_valid[0] = s2_valid_reg;
    assign div_data[0]  = s2_data_reg;

    // ------------------------------------------------------------------
    // Divider: two quotient bits per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_div
        dtd_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (div_valid[k]),
            .up_ready (div_ready[k]),
            .up_data  (div_data[k]),
            .dn_valid (div_valid[k+1]),
            .dn_ready (div_ready[k+1]),
            .dn_data  (div_data[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Output register: apply guards, range rules and saturation
    // ------------------------------------------------------------------
    logic                out_valid_reg;
    logic                out_ready;
    logic [DEPTH_W-1:0]  out_depth_reg;
    logic                out_inv_reg;
    logic [DEPTH_W-1:0]  depth_next;
    logic                int_over;
    dtd_div_t            fin;

    assign fin = div_data[DIV_STAGES];

    // Integer depth is over range when the exact quotient exceeds 65535:
    // any high bit set, or exactly 65535 with a nonzero remainder anywhere.
    assign int_over = fin.over
                   || (fin.qn[QUO_W-1:INT_DEPTH_W] != '0)
                   || ((fin.qn[INT_DEPTH_W-1:0] == '1)
                       && ((fin.rem != '0) || fin.frac_nz));

    always_comb
    begin
        if (fin.inv)
        begin
            depth_next = '0;
        end
        else if (format_reg == FMT_Q16)
        begin
            depth_next = fin.over ? '1 : fin.qn;
        end
        else
        begin
            depth_next = int_over ? '0 : DEPTH_W'(fin.qn[INT_DEPTH_W-1:0]);
        end
    end

    assign out_ready                = !out_valid_reg || result.ready;
    assign div_ready[DIV_STAGES]    = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= div_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && div_valid[DIV_STAGES])
        begin
            out_depth_reg <= depth_next;
            out_inv_reg   <= fin.inv;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.depth_value = out_depth_reg;
    assign result.invalid     = out_inv_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for disparity_to_depth_top.
// Depends on dtd_pkg, dtd_disp_if, dtd_depth_if and the block's RTL.
module tb;
    import dtd_pkg::*;

    // Pipeline depth from pixel acceptance to result, per the top level.
    localparam int PIPE_LATENCY = 18;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT_DEFAULT = 23;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PIXELS = 150;
    localparam int STEADY_PHASE = 4;

    // Integer depth ceiling and its scale: Q16.8 * Q16.8 / Q11.4 leaves Q.12.
    localparam logic [63:0] DEPTH_INT_MAX = 64'd65535;
    localparam logic [63:0] INT_SCALE = 64'd4096;
    localparam logic [63:0] Q16_MAX = 64'hFFFF_FFFF;
    localparam int Q16_SHIFT = 4;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth_value;
        logic               invalid;
    } depth_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    dtd_disp_if  pixel_ch ();
    dtd_depth_if result_ch ();

    disparity_to_depth_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel    (pixel_ch),
        .result   (result_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Local copy of the camera registers, kept in step with every write.
    logic [FACTOR_W-1:0] focal_cfg;
    logic [FACTOR_W-1:0] baseline_cfg;
    logic [CENTER_W-1:0] left_col_cfg;
    logic [CENTER_W-1:0] right_col_cfg;
    fmt_t                format_cfg;

    depth_item_t expected_depths[$];
    int          mismatch_count;
    int          idle_pct;
    int unsigned cycle_count;

    // Free-running clock, 10 time units per period.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: give up if the run hangs anywhere.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Triangulate one pixel: depth = focal * baseline / (disparity + offset),
    // with the offset only applied when both principal points are set.
    function automatic depth_item_t predict_depth(input logic signed [DISP_W-1:0] disp);
        depth_item_t r;
        int          offset;
        int          den;
        logic [63:0] prod;
        logic [63:0] uden;
        logic [63:0] quo;
        r = '0;
        offset = 0;
        // Non-positive disparity or an unset camera gives no depth at all.
        if (disp <= 0 || baseline_cfg == 0 || focal_cfg == 0)
        begin
            r.invalid = 1'b1;
            return r;
        end
        if (left_col_cfg != 0 && right_col_cfg != 0)
            offset = int'(right_col_cfg) - int'(left_col_cfg);
        den = int'(disp) + offset;
        // The offset can push the denominator to zero or below: flag it.
        if (den <= 0)
        begin
            r.invalid = 1'b1;
            return r;
        end
        uden = 64'(den);
        prod = 64'(focal_cfg) * 64'(baseline_cfg);
        if (format_cfg == FMT_INT)
        begin
            // Integer depth beyond 16 bits reads back as zero, not flagged.
            if (prod > DEPTH_INT_MAX * INT_SCALE * uden)
                quo = '0;
            else
                quo = prod / (INT_SCALE * uden);
        end
        else
        begin
            quo = (prod << Q16_SHIFT) / uden;
            if (quo > Q16_MAX)
                quo = Q16_MAX;
        end
        r.depth_value = quo[DEPTH_W-1:0];
        return r;
    endfunction

    // Result sink: hold ready low in reset, then stall at random unless a
    // steady stretch is running.
    always @(posedge clk)
        result_ch.ready <= rst_n && ($urandom_range(99) >= idle_pct);

    // Check every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        depth_item_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_depths.size() == 0)
            begin
                $error("depth result with none expected: depth_value %0d invalid %0b",
                       result_ch.depth_value, result_ch.invalid);
                mismatch_count++;
            end
            else
            begin
                want = expected_depths.pop_front();
                if (result_ch.depth_value !== want.depth_value)
                begin
                    $error("depth_value mismatch: expected %0d, actual %0d",
                           want.depth_value, result_ch.depth_value);
                    mismatch_count++;
                end
                if (result_ch.invalid !== want.invalid)
                begin
                    $error("invalid mismatch: expected %0b, actual %0b",
                           want.invalid, result_ch.invalid);
                    mismatch_count++;
                end
            end
        end
    end

    // Offer one pixel, idling first at random; return on the accepting edge.
    task automatic send_pixel(input logic signed [DISP_W-1:0] disp);
        while ($urandom_range(99) < idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid     <= 1'b1;
        pixel_ch.disparity <= disp;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        expected_depths = {expected_depths, predict_depth(disp)};
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe empty.
    task automatic settle_pipeline();
        pixel_ch.valid <= 1'b0;
        while (expected_depths.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    // Load all camera registers while the pipe is idle, plus one write to an
    // unused index that the block must ignore.
    task automatic program_camera(input logic [FACTOR_W-1:0] focal,
                                  input logic [FACTOR_W-1:0] baseline,
                                  input logic [CENTER_W-1:0] left_col,
                                  input logic [CENTER_W-1:0] right_col,
                                  input fmt_t fmt);
        logic [CFG_IDX_W-1:0] spare_idx;
        settle_pipeline();
        spare_idx = CFG_IDX_W'($urandom_range(int'(REG_FORMAT) + 1, (1 << CFG_IDX_W) - 1));
        reg_write(REG_FOCAL, CFG_DATA_W'(focal));
        reg_write(spare_idx, CFG_DATA_W'($urandom));
        reg_write(REG_BASELINE, CFG_DATA_W'(baseline));
        reg_write(REG_LEFT_COL, CFG_DATA_W'(left_col));
        reg_write(REG_RIGHT_COL, CFG_DATA_W'(right_col));
        reg_write(REG_FORMAT, CFG_DATA_W'(fmt));
        wr_en <= 1'b0;
        focal_cfg     = focal;
        baseline_cfg  = baseline;
        left_col_cfg  = left_col;
        right_col_cfg = right_col;
        format_cfg    = fmt;
    endtask

    // Registers left at reset: every pixel falls foul of the zero-focal guard.
    task automatic test_reset_defaults();
        send_pixel(16'sd16);
        send_pixel(-16'sd16);
        send_pixel(16'sd32767);
    endtask

    // Non-positive disparity, zero focal length, zero baseline and two valid pixels.
    task automatic test_input_guards();
        program_camera(24'h000100, 24'h000100, '0, '0, FMT_INT);
        send_pixel(16'sd0);
        send_pixel(-16'sd1);
        send_pixel(-16'sd32768);
        send_pixel(16'sd32767);
        send_pixel(16'sd1);
        program_camera(24'h000000, 24'h000100, '0, '0, FMT_Q16);
        send_pixel(16'sd64);
        program_camera(24'h000100, 24'h000000, '0, '0, FMT_Q16);
        send_pixel(16'sd64);
    endtask

    // Principal-point offset: denominator driven to zero, below zero, and the
    // offset dropped when one principal point is zero.
    task automatic test_center_offset();
        program_camera(24'h001000, 24'h002000, 16'h0200, 16'h0100, FMT_Q16);
        send_pixel(16'sd256);
        send_pixel(16'sd100);
        send_pixel(16'sd300);
        program_camera(24'h001000, 24'h002000, 16'h0000, 16'h0100, FMT_Q16);
        send_pixel(16'sd100);
    endtask

    // Integer depth at exactly 65535, one step past it and one well in range, then
    // the first pair in Q16.16 where the second saturates.
    task automatic test_depth_formats();
        program_camera(24'h00FFFF, 24'h010000, '0, '0, FMT_INT);
        send_pixel(16'sd16);
        send_pixel(16'sd15);
        send_pixel(16'sd4096);
        program_camera(24'h00FFFF, 24'h010000, '0, '0, FMT_Q16);
        send_pixel(16'sd16);
        send_pixel(16'sd15);
    endtask

    function automatic logic [FACTOR_W-1:0] rand_factor();
        case ($urandom_range(9))
            0:       return '1;
            1:       return FACTOR_W'(1);
            2:       return '0;
            default: return FACTOR_W'($urandom) >> $urandom_range(0, FACTOR_W - 1);
        endcase
    endfunction

    function automatic logic [CENTER_W-1:0] rand_center();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return CENTER_W'($urandom) >> $urandom_range(0, CENTER_W - 1);
        endcase
    endfunction

    // Mostly positive disparities spread over every magnitude, some raw
    // 16-bit noise and a few non-positive values.
    function automatic logic signed [DISP_W-1:0] rand_disparity();
        logic [DISP_W-1:0] mag;
        case ($urandom_range(9))
            0: return DISP_W'($urandom);
            1: return -DISP_W'($urandom_range(0, 4));
            default:
            begin
                mag = DISP_W'($urandom_range(1, 32767)) >> $urandom_range(0, DISP_W - 2);
                return (mag == 0) ? DISP_W'(1) : mag;
            end
        endcase
    endfunction

    // Random pixels under a run of camera settings, the extremes first and
    // one phase with neither side idling.
    task automatic test_random_pixels();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                program_camera('1, '1, '1, '1, FMT_Q16);
            else if (phase == 1)
                program_camera(FACTOR_W'(1), FACTOR_W'(1), CENTER_W'(1), '1, FMT_INT);
            else
                program_camera(rand_factor(), rand_factor(), rand_center(), rand_center(),
                               fmt_t'($urandom_range(1)));
            idle_pct = (phase == STEADY_PHASE) ? 0 : IDLE_PCT_DEFAULT;
            for (int n = 0; n < PHASE_PIXELS; n++)
                send_pixel(rand_disparity());
            idle_pct = IDLE_PCT_DEFAULT;
        end
    endtask

    // Hold every input at a known value, reset once, then run each test.
    initial
    begin
        rst_n              = 1'b0;
        wr_en              = 1'b0;
        wr_index           = '0;
        wr_data            = '0;
        pixel_ch.valid     = 1'b0;
        pixel_ch.disparity = '0;
        mismatch_count     = 0;
        idle_pct           = IDLE_PCT_DEFAULT;
        focal_cfg          = '0;
        baseline_cfg       = '0;
        left_col_cfg       = '0;
        right_col_cfg      = '0;
        format_cfg         = FMT_INT;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_input_guards();
        test_center_offset();
        test_depth_formats();
        test_random_pixels();
        settle_pipeline();

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dtd_pkg.sv
hw/rtl/dtd_disp_if.sv
hw/rtl/dtd_depth_if.sv
hw/rtl/dtd_div_stage.sv
hw/rtl/disparity_to_depth_top.sv
tb/tb.sv
